@@ hdl/power_mode_supervisor_fsm_core_macros.svh @@
// assertion macros for the power mode supervisor
// used by the core; no other dependencies
`ifndef POWER_MODE_SUPERVISOR_FSM_CORE_MACROS_SVH
`define POWER_MODE_SUPERVISOR_FSM_CORE_MACROS_SVH

`ifndef SYNTH
// clocked check, off while in reset
`define PMSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pmsf assertion failed");
// clocked check, also during reset
`define PMSF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pmsf assertion failed");
`else
`define PMSF_ASSERT(lbl, clk, rst_n, prop)
`define PMSF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hdl/pmsf_pkg.sv @@
// package for the power mode supervisor: item types, mode codes, register indexes
// no dependencies
package pmsf_pkg;

  localparam int unsigned FaultBits = 16;
  localparam int unsigned FaultW    = 16;
  localparam logic [FaultW-1:0] FaultFieldMask =
    (FaultBits >= FaultW) ? {FaultW{1'b1}} : FaultW'((17'(1) << FaultBits) - 17'(1));

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgP0Mask       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCritMask     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPollsNeeded  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPcLimit      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRailNominal  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRailSafe     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRailSurvival = 3'd6;

  localparam logic [1:0] ModeCodeStartup  = 2'd0;
  localparam logic [1:0] ModeCodeNominal  = 2'd1;
  localparam logic [1:0] ModeCodeSafe     = 2'd2;
  localparam logic [1:0] ModeCodeSurvival = 2'd3;

  localparam logic [2:0] LiveOk        = 3'd0;
  localparam logic [2:0] LiveBusStall  = 3'd1;
  localparam logic [2:0] LiveGpioStall = 3'd2;

  localparam logic [2:0] SevSurvival = 3'd0;
  localparam logic [2:0] SevSafe     = 3'd1;
  localparam logic [2:0] SevInfo     = 3'd4;
  localparam logic [2:0] SevNone     = 3'd0;

  localparam logic ReqPoll = 1'b0;
  localparam logic ReqBoot = 1'b1;

  typedef enum logic [3:0] {
    ModeStartup  = 4'b0001,
    ModeNominal  = 4'b0010,
    ModeSafe     = 4'b0100,
    ModeSurvival = 4'b1000
  } mode_e;

  typedef struct packed {
    logic              req_type;
    logic [FaultW-1:0] fault_bitmap;
    logic [2:0]        live_state;
    logic [7:0]        powercycle_count;
    logic [7:0]        boot_code;
  } pmsf_in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rail_mask;
    logic       publish;
    logic       boot_valid;
    logic [7:0] boot_out;
    logic [7:0] cmd_seq;
    logic       mode_changed;
    logic [1:0] mode_before;
    logic [2:0] log_severity;
  } pmsf_out_t;

  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    case (m)
      ModeStartup:  c = ModeCodeStartup;
      ModeNominal:  c = ModeCodeNominal;
      ModeSafe:     c = ModeCodeSafe;
      ModeSurvival: c = ModeCodeSurvival;
      default:      c = ModeCodeStartup;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/power_mode_supervisor_fsm_core.sv @@
// power mode supervisor core: input register, mode fsm, result register
// depends on pmsf_pkg and power_mode_supervisor_fsm_core_macros.svh
`include "power_mode_supervisor_fsm_core_macros.svh"

// Takes one poll or boot item per clock cycle while the output is not stalled and returns exactly
// one result item for each; an item passes through the input register and then the result
// register before its result item is valid. An item is captured in the input register; while it
// is held there, a single pass of compare logic on the registered mode updates the mode, rail mask,
// clean-poll count and sequence number and loads the result register. The single-pass mode update sets
// the rate; output stall backs up through the two registers. Configuration writes take effect at the
// next clock edge.
module power_mode_supervisor_fsm_core import pmsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pmsf_in_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pmsf_out_t           out_item_o
);

  logic [FaultW-1:0] p0_mask_q, crit_mask_q;
  logic [7:0]        polls_needed_q, pc_limit_q;
  logic [7:0]        rail_nom_q, rail_safe_q, rail_surv_q;

  logic      s1_valid_q, s1_valid_d;
  pmsf_in_t  s1_q;
  logic      out_valid_q, out_valid_d;
  pmsf_out_t out_q, out_d;

  mode_e      mode_q, mode_d;
  logic [7:0] rail_q, rail_d;
  logic [7:0] clean_q, clean_d;
  logic [7:0] seq_q, seq_d;

  logic              out_ready, advance, in_take;
  logic [FaultW-1:0] faults;
  logic              p0, crit, pub, bvalid;
  logic [7:0]        clean_inc;
  logic [2:0]        sev;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_mask_q      <= '0;
      crit_mask_q    <= '0;
      polls_needed_q <= 8'd3;
      pc_limit_q     <= 8'd3;
      rail_nom_q     <= 8'd255;
      rail_safe_q    <= 8'd3;
      rail_surv_q    <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgP0Mask:       p0_mask_q      <= cfg_wdata_i;
        CfgCritMask:     crit_mask_q    <= cfg_wdata_i;
        CfgPollsNeeded:  polls_needed_q <= cfg_wdata_i[7:0];
        CfgPcLimit:      pc_limit_q     <= cfg_wdata_i[7:0];
        CfgRailNominal:  rail_nom_q     <= cfg_wdata_i[7:0];
        CfgRailSafe:     rail_safe_q    <= cfg_wdata_i[7:0];
        CfgRailSurvival: rail_surv_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_take || (s1_valid_q && !out_ready);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // mode logic
  assign faults    = s1_q.fault_bitmap & FaultFieldMask;
  assign p0        = |(faults & p0_mask_q);
  assign crit      = (|(faults & crit_mask_q)) || (s1_q.powercycle_count >= pc_limit_q);
  assign clean_inc = (clean_q == 8'd255) ? clean_q : clean_q + 8'd1;

  always_comb begin
    mode_d  = mode_q;
    rail_d  = rail_q;
    clean_d = clean_q;
    pub     = 1'b0;
    bvalid  = 1'b0;
    if (s1_q.req_type == ReqBoot) begin
      pub    = 1'b1;
      bvalid = 1'b1;
    end else begin
      case (mode_q)
        ModeStartup: begin
          if (!p0 && s1_q.live_state <= LiveBusStall) begin
            clean_d = clean_inc;
            if (clean_inc >= polls_needed_q) begin
              mode_d = ModeNominal;
              rail_d = rail_nom_q;
              pub    = 1'b1;
            end
          end else begin
            clean_d = '0;
          end
        end
        ModeNominal: begin
          if (crit) begin
            mode_d = ModeSurvival;
            rail_d = rail_surv_q;
            pub    = 1'b1;
          end else if (p0 || s1_q.live_state >= LiveGpioStall) begin
            mode_d = ModeSafe;
            rail_d = rail_safe_q;
            pub    = 1'b1;
          end
        end
        ModeSafe: begin
          if (crit) begin
            mode_d = ModeSurvival;
            rail_d = rail_surv_q;
            pub    = 1'b1;
          end else if (!p0 && s1_q.live_state == LiveOk) begin
            mode_d = ModeNominal;
            rail_d = rail_nom_q;
            pub    = 1'b1;
          end
        end
        default: begin
          rail_d = rail_surv_q;
        end
      endcase
    end
    seq_d = pub ? seq_q + 8'd1 : seq_q;

    if (mode_d == mode_q) begin
      sev = SevNone;
    end else if (mode_d == ModeSurvival) begin
      sev = SevSurvival;
    end else if (mode_d == ModeSafe) begin
      sev = SevSafe;
    end else begin
      sev = SevInfo;
    end

    out_d.mode         = mode_code(mode_d);
    out_d.rail_mask    = rail_d;
    out_d.publish      = pub;
    out_d.boot_valid   = bvalid;
    out_d.boot_out     = bvalid ? s1_q.boot_code : 8'd0;
    out_d.cmd_seq      = seq_d;
    out_d.mode_changed = (mode_d != mode_q);
    out_d.mode_before  = mode_code(mode_q);
    out_d.log_severity = sev;
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeStartup;
      rail_q      <= 8'd1;
      clean_q     <= '0;
      seq_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        mode_q  <= mode_d;
        rail_q  <= rail_d;
        clean_q <= clean_d;
        seq_q   <= seq_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PMSF_ASSERT(a_survival_sticks, clk_i, rst_ni, mode_q == ModeSurvival |=> mode_q == ModeSurvival)
  `PMSF_ASSERT(a_state_holds_idle, clk_i, rst_ni, !advance |=> $stable(mode_q) && $stable(seq_q))
  `PMSF_ASSERT(a_seq_steps, clk_i, rst_ni, advance && pub |=> seq_q == $past(seq_q) + 8'd1)
  `PMSF_ASSERT(a_seq_matches_out, clk_i, rst_ni, advance |=> out_q.cmd_seq == seq_q)
  `PMSF_ASSERT_ALWAYS(a_stall_needs_item, clk_i, in_stall_o |-> s1_valid_q)

endmodule

@@ bench/power_mode_supervisor_fsm_core_test.sv @@
// testbench for power_mode_supervisor_fsm_core: random and directed poll and boot items,
// checked against an in-bench model of the mode fsm under bursty input and output stalls
// depends on pmsf_pkg and the core rtl
`timescale 1ns / 100ps

module power_mode_supervisor_fsm_core_test;
  import pmsf_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 200;

  localparam int unsigned GenNoCrit = 0;
  localparam int unsigned GenAny    = 1;
  localparam int unsigned GenClean  = 2;
  localparam int unsigned GenBoot   = 3;

  localparam int unsigned StallNone    = 0;
  localparam int unsigned StallRandom  = 1;
  localparam int unsigned StallPattern = 2;
  localparam int unsigned StallHeavy   = 3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pmsf_in_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pmsf_out_t           out_item_o;

  // register copies and fsm state of the model
  logic [15:0] cfg_p0 = 16'h0000;
  logic [15:0] cfg_crit = 16'h0000;
  logic [7:0]  cfg_polls = 8'd3;
  logic [7:0]  cfg_pc_limit = 8'd3;
  logic [7:0]  cfg_rail_nom = 8'hFF;
  logic [7:0]  cfg_rail_safe = 8'h03;
  logic [7:0]  cfg_rail_surv = 8'h01;
  logic [1:0]  cur_mode = ModeCodeStartup;
  logic [7:0]  rail_now = 8'h01;
  logic [7:0]  clean_polls = 8'd0;
  logic [7:0]  seq_no = 8'd0;
  bit          seq_wrapped = 1'b0;

  pmsf_in_t    poll_queue[$];
  pmsf_out_t   due_status[$];
  int unsigned mismatches = 0;

  bit          sender_gaps = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_style = StallNone;
  bit          hold_wanted = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_tick = 0;
  int unsigned idle_cycles = 0;

  power_mode_supervisor_fsm_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void predict_supervisor_step(input pmsf_in_t it);
    pmsf_out_t   r;
    logic [15:0] faults;
    logic        p0_hit;
    logic        crit_hit;
    logic        sent;
    logic [1:0]  from_mode;
    logic [1:0]  to_mode;
    r = '0;
    faults = it.fault_bitmap & FaultFieldMask;
    p0_hit = |(faults & cfg_p0);
    crit_hit = (|(faults & cfg_crit)) || (it.powercycle_count >= cfg_pc_limit);
    from_mode = cur_mode;
    to_mode = cur_mode;
    sent = 1'b0;
    if (it.req_type == ReqBoot) begin
      sent = 1'b1;
      r.boot_valid = 1'b1;
      r.boot_out = it.boot_code;
    end else begin
      case (cur_mode)
        ModeCodeStartup: begin
          if (!p0_hit && it.live_state <= LiveBusStall) begin
            if (clean_polls != 8'hFF) clean_polls++;
            if (clean_polls >= cfg_polls) begin
              to_mode = ModeCodeNominal;
              rail_now = cfg_rail_nom;
              sent = 1'b1;
            end
          end else begin
            clean_polls = 8'd0;
          end
        end
        ModeCodeNominal: begin
          if (crit_hit) begin
            to_mode = ModeCodeSurvival;
            rail_now = cfg_rail_surv;
            sent = 1'b1;
          end else if (p0_hit || it.live_state >= LiveGpioStall) begin
            to_mode = ModeCodeSafe;
            rail_now = cfg_rail_safe;
            sent = 1'b1;
          end
        end
        ModeCodeSafe: begin
          if (crit_hit) begin
            to_mode = ModeCodeSurvival;
            rail_now = cfg_rail_surv;
            sent = 1'b1;
          end else if (!p0_hit && it.live_state == LiveOk) begin
            to_mode = ModeCodeNominal;
            rail_now = cfg_rail_nom;
            sent = 1'b1;
          end
        end
        default: rail_now = cfg_rail_surv;
      endcase
    end
    if (sent) begin
      seq_no++;
      if (seq_no == 8'd0) seq_wrapped = 1'b1;
    end
    cur_mode = to_mode;
    r.mode = to_mode;
    r.rail_mask = rail_now;
    r.publish = sent;
    r.cmd_seq = seq_no;
    r.mode_changed = (to_mode != from_mode);
    r.mode_before = from_mode;
    if (to_mode == from_mode) r.log_severity = SevNone;
    else if (to_mode == ModeCodeSurvival) r.log_severity = SevSurvival;
    else if (to_mode == ModeCodeSafe) r.log_severity = SevSafe;
    else r.log_severity = SevInfo;
    due_status.push_back(r);
  endfunction

  function automatic pmsf_in_t item_of(input logic req, input logic [15:0] faults,
                                       input logic [2:0] live, input logic [7:0] pcc,
                                       input logic [7:0] code);
    pmsf_in_t it;
    it.req_type = req;
    it.fault_bitmap = faults;
    it.live_state = live;
    it.powercycle_count = pcc;
    it.boot_code = code;
    return it;
  endfunction

  function automatic pmsf_in_t make_item(input int unsigned flavor);
    pmsf_in_t    it;
    int unsigned roll;
    it.req_type = ReqPoll;
    it.fault_bitmap = 16'($urandom);
    it.live_state = 3'($urandom);
    it.powercycle_count = 8'($urandom);
    it.boot_code = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (flavor == GenBoot || roll < 22) begin
      it.req_type = ReqBoot;
    end else if (flavor == GenClean) begin
      it.fault_bitmap &= ~cfg_p0;
      it.live_state = roll[0] ? LiveBusStall : LiveOk;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) it.fault_bitmap = '0;
      else if (roll < 70) it.fault_bitmap = 16'(1) << $urandom_range(0, 15);
      roll = $urandom_range(0, 99);
      if (roll < 50) it.live_state = LiveOk;
      else if (roll < 65) it.live_state = LiveBusStall;
      if (flavor == GenNoCrit) begin
        it.fault_bitmap &= ~cfg_crit;
        if (it.powercycle_count >= cfg_pc_limit)
          it.powercycle_count = 8'($urandom_range(0, cfg_pc_limit - 1));
      end
    end
    return it;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_status(input pmsf_out_t want, input pmsf_out_t got);
    check_field("mode", want.mode, got.mode);
    check_field("rail_mask", want.rail_mask, got.rail_mask);
    check_field("publish", want.publish, got.publish);
    check_field("boot_valid", want.boot_valid, got.boot_valid);
    check_field("boot_out", want.boot_out, got.boot_out);
    check_field("cmd_seq", want.cmd_seq, got.cmd_seq);
    check_field("mode_changed", want.mode_changed, got.mode_changed);
    check_field("mode_before", want.mode_before, got.mode_before);
    check_field("log_severity", want.log_severity, got.log_severity);
  endtask

  // sender: bursts of items, with random gaps in between when sender_gaps is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_supervisor_step(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (poll_queue.size() != 0) begin
          in_item_i <= poll_queue.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = sender_gaps ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result item and drives its own stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_status.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, out_item_o);
          mismatches++;
        end else begin
          check_status(due_status.pop_front(), out_item_o);
        end
      end
      rx_tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_wanted && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_style)
          StallNone:    out_stall_i <= 1'b0;
          StallRandom:  out_stall_i <= ($urandom_range(0, 99) < 30);
          StallPattern: out_stall_i <= ((rx_tick % 7) < 3);
          default:      out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (poll_queue.size() != 0 || in_valid_i || due_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic apply_config(input logic [15:0] p0, input logic [15:0] crit,
                              input logic [7:0] polls, input logic [7:0] pc_lim,
                              input logic [7:0] r_nom, input logic [7:0] r_safe,
                              input logic [7:0] r_surv);
    cfg_p0 = p0;
    cfg_crit = crit;
    cfg_polls = polls;
    cfg_pc_limit = pc_lim;
    cfg_rail_nom = r_nom;
    cfg_rail_safe = r_safe;
    cfg_rail_surv = r_surv;
    write_reg(CfgP0Mask, p0);
    write_reg(CfgCritMask, crit);
    write_reg(CfgPollsNeeded, CfgDataW'(polls));
    write_reg(CfgPcLimit, CfgDataW'(pc_lim));
    write_reg(CfgRailNominal, CfgDataW'(r_nom));
    write_reg(CfgRailSafe, CfgDataW'(r_safe));
    write_reg(CfgRailSurvival, CfgDataW'(r_surv));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned flavor,
                           input bit gaps, input int unsigned style);
    sender_gaps = gaps;
    stall_style = style;
    repeat (count) poll_queue.push_back(make_item(flavor));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // startup under reset settings: boots, clean and dirty polls
    poll_queue.push_back(item_of(ReqBoot, 16'h0000, LiveOk, 8'h00, 8'h00));
    poll_queue.push_back(item_of(ReqBoot, 16'hFFFF, 3'd7, 8'hFF, 8'hFF));
    poll_queue.push_back(item_of(ReqPoll, 16'hFFFF, LiveBusStall, 8'hFF, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveGpioStall, 8'h00, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, 3'd7, 8'h00, 8'hA5));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveOk, 8'h00, 8'h00));
    poll_queue.push_back(item_of(ReqBoot, 16'h0000, LiveOk, 8'h00, 8'h5A));
    poll_queue.push_back(item_of(ReqPoll, 16'h5555, LiveOk, 8'h80, 8'h00));
    drain();

    apply_config(16'h00F0, 16'hC000, 8'd255, 8'd200, 8'hFE, 8'h06, 8'h81);
    poll_queue.push_back(item_of(ReqPoll, 16'h0010, LiveOk, 8'h00, 8'h00));
    run_phase(30, GenClean, 1'b1, StallRandom);

    // leave startup, then walk nominal and safe
    apply_config(16'h00F0, 16'hC000, 8'd1, 8'd200, 8'hFE, 8'h06, 8'h81);
    poll_queue.push_back(item_of(ReqPoll, 16'h0001, LiveBusStall, 8'd10, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveGpioStall, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveBusStall, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0080, LiveOk, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqBoot, 16'h0000, LiveOk, 8'd0, 8'h3C));
    poll_queue.push_back(item_of(ReqPoll, 16'h0100, LiveOk, 8'd199, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0020, LiveOk, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveOk, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveBusStall, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, 3'd7, 8'd0, 8'h00));
    drain();

    run_phase(70, GenNoCrit, 1'b1, StallRandom);

    // long receiver hold while the sender keeps offering
    apply_config(16'hFFFF, 16'h0000, 8'd1, 8'd255, 8'hFF, 8'h00, 8'h00);
    sender_gaps = 1'b0;
    stall_style = StallNone;
    repeat (60) poll_queue.push_back(make_item(GenNoCrit));
    hold_wanted = 1'b1;
    drain();

    apply_config(16'h0000, 16'h0000, 8'd1, 8'd255, 8'h00, 8'hFF, 8'hFF);
    run_phase(70, GenNoCrit, 1'b0, StallPattern);

    apply_config(16'($urandom), 16'($urandom & $urandom), 8'($urandom_range(1, 255)),
                 8'($urandom_range(100, 255)), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(70, GenNoCrit, 1'b1, StallHeavy);

    // critical fault from safe, then anything
    apply_config(16'($urandom), 16'h8001, 8'd1, 8'd128, 8'h3C, 8'hC3, 8'h81);
    poll_queue.push_back(item_of(ReqPoll, 16'h0000, LiveGpioStall, 8'd0, 8'h00));
    poll_queue.push_back(item_of(ReqPoll, 16'h8000, LiveOk, 8'd0, 8'h00));
    run_phase(40, GenAny, 1'b1, StallRandom);

    // survival polls pick up the new survival rail mask
    apply_config(16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 8'h00, 8'hFF, 8'h5A);
    run_phase(20, GenAny, 1'b0, StallNone);

    while (!seq_wrapped) run_phase(40, GenBoot, 1'b1, StallPattern);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/pmsf_pkg.sv
hdl/power_mode_supervisor_fsm_core.sv
bench/power_mode_supervisor_fsm_core_test.sv
